[src/mbs_pkg.sv]
package mbs_pkg;

	localparam int unsigned MS_PER_MINUTE  = 60000;
	localparam int unsigned PRESS_SAT      = 1023;
	localparam int unsigned DEBOUNCE_RESET = 200;
	localparam int unsigned NUM_SIGNATURES = 6;

	localparam int unsigned QUO_W  = 16;
	localparam int unsigned DIV_W  = 11;
	localparam int unsigned REM_W  = DIV_W + 1;
	localparam int unsigned STEP_W = 4;

	localparam logic       KIND_TICK  = 1'b0;
	localparam logic       KIND_PRESS = 1'b1;

	localparam logic [1:0] ACCENT_NONE   = 2'd0;
	localparam logic [1:0] ACCENT_STRONG = 2'd1;
	localparam logic [1:0] ACCENT_WEAK   = 2'd2;

	localparam logic [2:0] LAMP_NONE = 3'd0;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic take;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_busy;
	} status_t;

	function automatic logic [3:0] sig_numer(input logic [2:0] sig);
		logic [3:0] r;
		case (sig)
			3'd1: r = 4'd3;
			3'd2: r = 4'd4;
			3'd3: r = 4'd6;
			3'd4: r = 4'd9;
			3'd5: r = 4'd12;
			default: r = 4'd2;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] sig_denom(input logic [2:0] sig);
		logic [3:0] r;
		case (sig)
			3'd3, 3'd4, 3'd5: r = 4'd8;
			default: r = 4'd4;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] sig_beats(input logic [2:0] sig);
		logic [2:0] r;
		case (sig)
			3'd1, 3'd4: r = 3'd3;
			3'd2, 3'd5: r = 3'd4;
			default: r = 3'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] sig_subs(input logic [2:0] sig);
		logic [1:0] r;
		case (sig)
			3'd3, 3'd4, 3'd5: r = 2'd3;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

[src/mbs_ctrl.sv]
module mbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  mbs_pkg::status_t status,
	output logic            in_ready,
	output mbs_pkg::cmd_t   cmd
);
	import mbs_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && status.need_div) begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.take   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !status.out_busy || out_ready;
				cmd.take = in_valid && in_ready;
			end
			ST_DIV: begin
				cmd.step   = 1'b1;
				cmd.finish = status.div_last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[src/mbs_datapath.sv]
module mbs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mbs_pkg::cmd_t    cmd,
	output mbs_pkg::status_t status,
	input  logic             kind,
	input  logic [8:0]       tempo_bpm,
	input  logic             cfg_we,
	input  logic [9:0]       cfg_wdata,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [2:0]       lamp_color,
	output logic [1:0]       accent_tone,
	output logic             click,
	output logic [3:0]       bar_beats,
	output logic [3:0]       beat_unit,
	output logic             press_taken
);
	import mbs_pkg::*;

	logic [9:0]        debounce_q;
	logic [2:0]        sel_sig_q;
	logic [2:0]        play_sig_q;
	logic [1:0]        beat_pos_q;
	logic [1:0]        slot_pos_q;
	logic [QUO_W-1:0]  slot_left_q;
	logic [QUO_W-1:0]  slot_len_q;
	logic [9:0]        ms_press_q;

	logic [DIV_W-1:0]  divisor_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_cnt_q;

	logic              out_valid_q;
	logic [2:0]        lamp_q;
	logic [1:0]        accent_q;
	logic              click_q;
	logic              taken_q;

	logic              is_tick;
	logic              slot_start;
	logic              bar_start;
	logic [2:0]        sig_now;
	logic [2:0]        beats_now;
	logic [1:0]        subs_now;
	logic [8:0]        bpm_eff;
	logic [DIV_W-1:0]  divisor_new;
	logic [2:0]        slot_inc;
	logic [2:0]        beat_inc;
	logic              press_ok;
	logic [2:0]        sel_next;
	logic [REM_W-1:0]  rem_shift;
	logic              quo_bit;
	logic [REM_W-1:0]  rem_next;
	logic [QUO_W-1:0]  quo_next;

	assign is_tick    = (kind == KIND_TICK);
	assign slot_start = (slot_left_q == '0);
	assign bar_start  = (slot_pos_q == 2'd0) && (beat_pos_q == 2'd0);
	assign sig_now    = bar_start ? sel_sig_q : play_sig_q;
	assign beats_now  = sig_beats(sig_now);
	assign subs_now   = sig_subs(sig_now);
	assign bpm_eff    = (tempo_bpm == '0) ? 9'd1 : tempo_bpm;
	assign divisor_new = (subs_now == 2'd3)
		? ({2'b00, bpm_eff} + {1'b0, bpm_eff, 1'b0})
		: {1'b0, bpm_eff, 1'b0};
	assign slot_inc   = {1'b0, slot_pos_q} + 3'd1;
	assign beat_inc   = {1'b0, beat_pos_q} + 3'd1;
	assign press_ok   = (ms_press_q >= debounce_q);
	assign sel_next   = (sel_sig_q == 3'(NUM_SIGNATURES - 1)) ? 3'd0 : sel_sig_q + 3'd1;

	assign rem_shift  = {rem_q[REM_W-2:0], quo_q[QUO_W-1]};
	assign quo_bit    = (rem_shift >= {1'b0, divisor_q});
	assign rem_next   = quo_bit ? rem_shift - {1'b0, divisor_q} : rem_shift;
	assign quo_next   = {quo_q[QUO_W-2:0], quo_bit};

	assign status.need_div = is_tick && slot_start && (slot_pos_q == 2'd0);
	assign status.div_last = (step_cnt_q == '0);
	assign status.out_busy = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= 10'(DEBOUNCE_RESET);
			sel_sig_q   <= '0;
			play_sig_q  <= '0;
			beat_pos_q  <= '0;
			slot_pos_q  <= '0;
			slot_left_q <= '0;
			slot_len_q  <= '0;
			ms_press_q  <= 10'(PRESS_SAT);
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				debounce_q <= cfg_wdata;
			end
			if (cmd.take) begin
				if (is_tick) begin
					if (ms_press_q != 10'(PRESS_SAT)) begin
						ms_press_q <= ms_press_q + 10'd1;
					end
					if (slot_start) begin
						if (bar_start) begin
							play_sig_q <= sel_sig_q;
						end
						if (slot_pos_q == 2'd0) begin
							step_cnt_q <= STEP_W'(QUO_W - 1);
						end else if (slot_len_q != '0) begin
							slot_left_q <= slot_len_q - 16'd1;
						end else begin
							slot_left_q <= '0;
						end
						if (slot_inc >= {1'b0, subs_now}) begin
							slot_pos_q <= '0;
							if (beat_inc >= beats_now) begin
								beat_pos_q <= '0;
							end else begin
								beat_pos_q <= beat_inc[1:0];
							end
						end else begin
							slot_pos_q <= slot_inc[1:0];
						end
					end else begin
						slot_left_q <= slot_left_q - 16'd1;
					end
				end else if (press_ok) begin
					sel_sig_q  <= sel_next;
					ms_press_q <= '0;
				end
			end
			if (cmd.step) begin
				step_cnt_q <= step_cnt_q - STEP_W'(1);
			end
			if (cmd.finish) begin
				slot_len_q  <= quo_next;
				slot_left_q <= (quo_next != '0) ? quo_next - 16'd1 : '0;
			end
			if ((cmd.take && !status.need_div) || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			divisor_q <= divisor_new;
			rem_q     <= '0;
			quo_q     <= QUO_W'(MS_PER_MINUTE);
			lamp_q    <= LAMP_NONE;
			accent_q  <= ACCENT_NONE;
			click_q   <= 1'b0;
			taken_q   <= 1'b0;
			if (is_tick) begin
				if (slot_start) begin
					click_q <= 1'b1;
					if (slot_pos_q == 2'd0) begin
						lamp_q   <= {1'b0, beat_pos_q} + 3'd1;
						accent_q <= (beat_pos_q == 2'd0) ? ACCENT_STRONG : ACCENT_WEAK;
					end
				end
			end else begin
				taken_q <= press_ok;
			end
		end else if (cmd.step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign lamp_color  = lamp_q;
	assign accent_tone = accent_q;
	assign click       = click_q;
	assign press_taken = taken_q;
	assign bar_beats   = sig_numer(sel_sig_q);
	assign beat_unit   = sig_denom(sel_sig_q);

endmodule

[src/metronome_bar_sequencer.sv]
// A press, or a tick that starts no beat, gives its result in the cycle after acceptance.
// A tick that starts a beat runs the 16-step slot length divider and gives its result
// after the division has finished, and no next item is taken before then.
// Throughput: one item per cycle while the output is not stalled, none while a division runs.
// Reset clears the sequencer to 2/4, first slot pending, debounce 200 ms, no result held.
module metronome_bar_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [8:0] tempo_bpm,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] lamp_color,
	output logic [1:0] accent_tone,
	output logic       click,
	output logic [3:0] bar_beats,
	output logic [3:0] beat_unit,
	output logic       press_taken,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata
);
	import mbs_pkg::*;

	cmd_t    cmd;
	status_t status;

	mbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	mbs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.kind        (kind),
		.tempo_bpm   (tempo_bpm),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.lamp_color  (lamp_color),
		.accent_tone (accent_tone),
		.click       (click),
		.bar_beats   (bar_beats),
		.beat_unit   (beat_unit),
		.press_taken (press_taken)
	);

	a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in_ready)
		else $error("item accepted while the divider is running");

	a_result_after_division: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("no result after the division finished");

	a_division_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && status.need_div) |=> (cmd.step && !out_valid))
		else $error("beat start did not enter the divider");

endmodule

[bench/tb_metronome_bar_sequencer.sv]
`timescale 1ns / 1ps

module tb_metronome_bar_sequencer;
	import mbs_pkg::*;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned PHASES = 7;
	localparam int unsigned PHASE_ITEMS = 260;

	localparam logic [2:0] LAMP_RED = 3'd1;

	localparam logic [2:0] SIG_2_4  = 3'd0;
	localparam logic [2:0] SIG_3_4  = 3'd1;
	localparam logic [2:0] SIG_4_4  = 3'd2;
	localparam logic [2:0] SIG_6_8  = 3'd3;
	localparam logic [2:0] SIG_9_8  = 3'd4;
	localparam logic [2:0] SIG_12_8 = 3'd5;

	typedef struct packed {
		logic [2:0] lamp;
		logic [1:0] accent;
		logic       click;
		logic [3:0] beats;
		logic [3:0] unit;
		logic       taken;
	} metro_out_t;

	typedef struct packed {
		logic [3:0] numer;
		logic [3:0] denom;
		logic [2:0] beats;
		logic [1:0] subs;
	} sig_shape_t;

	typedef struct {
		bit         is_cfg;
		logic [9:0] cfg_val;
		logic       k;
		logic [8:0] bpm;
		bit         typed;
		metro_out_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [8:0] tempo_bpm;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] lamp_color;
	logic [1:0] accent_tone;
	logic       click;
	logic [3:0] bar_beats;
	logic [3:0] beat_unit;
	logic       press_taken;
	logic       cfg_we;
	logic [9:0] cfg_wdata;

	metronome_bar_sequencer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.tempo_bpm  (tempo_bpm),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.lamp_color (lamp_color),
		.accent_tone(accent_tone),
		.click      (click),
		.bar_beats  (bar_beats),
		.beat_unit  (beat_unit),
		.press_taken(press_taken),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	logic [9:0]  debounce_ms;
	logic [2:0]  sel_sig;
	logic [2:0]  play_sig;
	logic [1:0]  beat_idx;
	logic [1:0]  slot_idx;
	logic [15:0] slot_ms_left;
	logic [15:0] slot_len_ms;
	logic [9:0]  ms_since_press;

	metro_out_t  pending_outs[$];
	stim_row_t   directed_rows[$];
	int          fail_count;
	int unsigned idle_cycles;
	bit          calm;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic sig_shape_t shape_of(input logic [2:0] code);
		sig_shape_t s;
		case (code)
			SIG_3_4:  s = {4'd3, 4'd4, 3'd3, 2'd2};
			SIG_4_4:  s = {4'd4, 4'd4, 3'd4, 2'd2};
			SIG_6_8:  s = {4'd6, 4'd8, 3'd2, 2'd3};
			SIG_9_8:  s = {4'd9, 4'd8, 3'd3, 2'd3};
			SIG_12_8: s = {4'd12, 4'd8, 3'd4, 2'd3};
			default:  s = {4'd2, 4'd4, 3'd2, 2'd2};
		endcase
		return s;
	endfunction

	function automatic metro_out_t mk_out(input logic [2:0] lamp, input logic [1:0] accent,
			input logic clk_bit, input logic [3:0] beats, input logic [3:0] unit,
			input logic taken);
		metro_out_t o;
		o.lamp   = lamp;
		o.accent = accent;
		o.click  = clk_bit;
		o.beats  = beats;
		o.unit   = unit;
		o.taken  = taken;
		return o;
	endfunction

	function automatic bit beat_due();
		return slot_ms_left == 16'd0 && slot_idx == 2'd0;
	endfunction

	// Advances the sequencer copy by one item and returns what the block should report.
	function automatic metro_out_t next_metronome_out(input logic k, input logic [8:0] bpm);
		metro_out_t  o;
		sig_shape_t  shape;
		int unsigned divisor;
		int unsigned next_slot;
		int unsigned next_beat;
		o = '0;
		if (k == KIND_TICK) begin
			if (ms_since_press != PRESS_SAT[9:0])
				ms_since_press = ms_since_press + 10'd1;
			if (slot_ms_left == 16'd0) begin
				if (slot_idx == 2'd0 && beat_idx == 2'd0)
					play_sig = sel_sig;
				shape = shape_of(play_sig);
				if (slot_idx == 2'd0) begin
					divisor = (bpm == 9'd0 ? 1 : int'(bpm)) * int'(shape.subs);
					slot_len_ms = 16'(MS_PER_MINUTE / divisor);
					o.lamp = 3'(beat_idx) + 3'd1;
					o.accent = (beat_idx == 2'd0) ? ACCENT_STRONG : ACCENT_WEAK;
				end
				o.click = 1'b1;
				slot_ms_left = slot_len_ms;
				next_slot = int'(slot_idx) + 1;
				next_beat = int'(beat_idx);
				if (next_slot >= int'(shape.subs)) begin
					next_slot = 0;
					next_beat = next_beat + 1;
					if (next_beat >= int'(shape.beats))
						next_beat = 0;
				end
				slot_idx = 2'(next_slot);
				beat_idx = 2'(next_beat);
			end
			if (slot_ms_left != 16'd0)
				slot_ms_left = slot_ms_left - 16'd1;
		end else begin
			if (ms_since_press >= debounce_ms) begin
				sel_sig = (sel_sig == SIG_12_8) ? SIG_2_4 : sel_sig + 3'd1;
				ms_since_press = 10'd0;
				o.taken = 1'b1;
			end
		end
		shape = shape_of(sel_sig);
		o.beats = shape.numer;
		o.unit = shape.denom;
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic k, input logic [8:0] bpm, input bit typed,
			input metro_out_t want);
		int         g;
		metro_out_t got;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		tempo_bpm <= bpm;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = next_metronome_out(k, bpm);
		pending_outs.push_back(typed ? want : got);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outs.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_debounce(input logic [9:0] val);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		debounce_ms = val;
	endtask

	task automatic add_row(input bit is_cfg, input logic [9:0] cfg_val, input logic k,
			input logic [8:0] bpm, input bit typed, input metro_out_t want);
		stim_row_t row;
		row.is_cfg = is_cfg;
		row.cfg_val = cfg_val;
		row.k = k;
		row.bpm = bpm;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		metro_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outs.size() == 0) begin
				$display("%0t unexpected item: expected none, got lamp %0d tone %0d click %0d",
					$time, lamp_color, accent_tone, click);
				fail_count++;
			end else begin
				want = pending_outs.pop_front();
				check_field("lamp_color", int'(want.lamp), int'(lamp_color));
				check_field("accent_tone", int'(want.accent), int'(accent_tone));
				check_field("click", int'(want.click), int'(click));
				check_field("bar_beats", int'(want.beats), int'(bar_beats));
				check_field("beat_unit", int'(want.unit), int'(beat_unit));
				check_field("press_taken", int'(want.taken), int'(press_taken));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
				$display("[metronome_bar_sequencer] ERROR");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int g;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [9:0] phase_deb [PHASES];
		logic [8:0] bpm;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		tempo_bpm = 9'd0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 10'd0;
		fail_count = 0;
		idle_cycles = 0;
		calm = 1'b0;
		debounce_ms = DEBOUNCE_RESET[9:0];
		sel_sig = SIG_2_4;
		play_sig = SIG_2_4;
		beat_idx = 2'd0;
		slot_idx = 2'd0;
		slot_ms_left = 16'd0;
		slot_len_ms = 16'd0;
		ms_since_press = PRESS_SAT[9:0];

		phase_deb[0] = 10'd200;
		phase_deb[1] = 10'd0;
		phase_deb[2] = 10'd1023;
		phase_deb[3] = 10'($urandom_range(1, 1022));
		phase_deb[4] = 10'd1;
		phase_deb[5] = 10'($urandom_range(0, 300));
		phase_deb[6] = 10'd50;

		// After reset the press counter is saturated, so the longest debounce still lets one in.
		add_row(1, 10'd1023, KIND_TICK, 9'd0, 0, '0);
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd3, 4'd4, 1'b1));
		add_row(0, 10'd0, KIND_PRESS, 9'd511, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd3, 4'd4, 1'b0));
		// With no debounce every press steps the signature, wrapping after 12/8.
		add_row(1, 10'd0, KIND_TICK, 9'd0, 0, '0);
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd4, 4'd4, 1'b1));
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd6, 4'd8, 1'b1));
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd9, 4'd8, 1'b1));
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd12, 4'd8, 1'b1));
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd2, 4'd4, 1'b1));
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd3, 4'd4, 1'b1));
		add_row(0, 10'd0, KIND_TICK, 9'd511, 1,
			mk_out(LAMP_RED, ACCENT_STRONG, 1'b1, 4'd3, 4'd4, 1'b0));
		// The display follows the new selection while the bar in progress keeps playing.
		add_row(0, 10'd0, KIND_PRESS, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd4, 4'd4, 1'b1));
		add_row(0, 10'd0, KIND_TICK, 9'd0, 1,
			mk_out(LAMP_NONE, ACCENT_NONE, 1'b0, 4'd4, 4'd4, 1'b0));
		add_row(0, 10'd0, KIND_TICK, 9'd511, 0, '0);
		add_row(0, 10'd0, KIND_PRESS, 9'd511, 0, '0);
		add_row(0, 10'd0, KIND_TICK, 9'd256, 0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				set_debounce(directed_rows[i].cfg_val);
			else
				send_item(directed_rows[i].k, directed_rows[i].bpm, directed_rows[i].typed,
					directed_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_debounce(phase_deb[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 63) == 0)
					calm = !calm;
				if (p == 1 && i == PHASE_ITEMS / 2)
					drain_results();
				if ($urandom_range(0, 99) < 12) begin
					send_item(KIND_PRESS, 9'($urandom_range(0, 511)), 0, '0);
				end else if (beat_due()) begin
					// Fast tempos keep the slots short so that whole bars get played.
					if ($urandom_range(0, 9) == 0)
						bpm = 9'($urandom_range(120, 511));
					else
						bpm = 9'($urandom_range(300, 511));
					send_item(KIND_TICK, bpm, 0, '0);
				end else begin
					send_item(KIND_TICK, 9'($urandom_range(0, 511)), 0, '0);
				end
			end
		end

		// A zero tempo at a beat start gives the longest slot, so it comes last.
		while (!beat_due())
			send_item(KIND_TICK, 9'($urandom_range(300, 511)), 0, '0);
		send_item(KIND_TICK, 9'd0, 0, '0);

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[metronome_bar_sequencer] OK");
		else
			$display("[metronome_bar_sequencer] ERROR");
		$finish;
	end

endmodule
